// ===== rtl/risc_instruction_predecoder_macros.svh =====
// ----------------------------------------------------------------------------
// risc_instruction_predecoder assertion macros
// shared property wrappers, clocked on i_clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef RISC_INSTRUCTION_PREDECODER_MACROS_SVH
`define RISC_INSTRUCTION_PREDECODER_MACROS_SVH

// same-cycle implication
`define RPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("predecoder assertion failed");

// next-cycle implication
`define RPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("predecoder assertion failed");

`endif

// ===== rtl/rpd_pkg.sv =====
// ----------------------------------------------------------------------------
// rpd_pkg
// mnemonic codes, encoding constants and stage payload types
// ----------------------------------------------------------------------------
`default_nettype none

package rpd_pkg;

    typedef enum logic [6:0] {
        M_RTPS = 7'd0, M_NCLIP, M_OP, M_DPCS, M_INTPL, M_MVMVA, M_NCDS, M_CDP,
        M_NCDT, M_NCCS, M_CC, M_NCS, M_NCT, M_SQR, M_DCPL, M_DPCT, M_AVSZ3,
        M_AVSZ4, M_RTPT, M_GPF, M_GPL, M_NCCT,
        M_NOP = 7'd22, M_SLL, M_SRL, M_SRA, M_SLLV, M_SRLV, M_SRAV, M_JR,
        M_JALR, M_SYSCALL, M_BREAK, M_MFHI, M_MTHI, M_MFLO, M_MTLO, M_MULT,
        M_MULTU, M_DIV, M_DIVU, M_ADD, M_MOVE, M_ADDU, M_SUB, M_SUBU, M_AND,
        M_OR, M_XOR, M_NOR, M_SLT, M_SLTU,
        M_BLTZ = 7'd52, M_BGEZ, M_BLTZAL, M_BGEZAL,
        M_MFC0, M_CFC0, M_MTC0, M_CTC0, M_BC0F, M_BC0T, M_RFE,
        M_MFC2, M_CFC2, M_MTC2, M_CTC2, M_BC2F, M_BC2T,
        M_J = 7'd69, M_JAL, M_B, M_BEQZ, M_BEQ, M_BNEZ, M_BNE, M_BLEZ, M_BGTZ,
        M_ADDI, M_LI, M_ADDIU, M_SLTI, M_SLTIU, M_ANDI, M_ORI, M_XORI, M_LUI,
        M_LB, M_LH, M_LWL, M_LW, M_LBU, M_LHU, M_LWR, M_SB, M_SH, M_SWL, M_SW,
        M_SWR, M_LWC2, M_SWC2,
        M_UNKNOWN = 7'd101, M_GEO_UNNAMED
    } t_mnem;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_COP2    = 6'h12;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LWL     = 6'h22;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_LWR     = 6'h26;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SWL     = 6'h2A;
    localparam logic [5:0] OP_SW      = 6'h2B;
    localparam logic [5:0] OP_SWR     = 6'h2E;
    localparam logic [5:0] OP_LWC2    = 6'h32;
    localparam logic [5:0] OP_SWC2    = 6'h3A;

    // special function field
    localparam logic [5:0] F_SLL     = 6'h00;
    localparam logic [5:0] F_SRL     = 6'h02;
    localparam logic [5:0] F_SRA     = 6'h03;
    localparam logic [5:0] F_SLLV    = 6'h04;
    localparam logic [5:0] F_SRLV    = 6'h06;
    localparam logic [5:0] F_SRAV    = 6'h07;
    localparam logic [5:0] F_JR      = 6'h08;
    localparam logic [5:0] F_JALR    = 6'h09;
    localparam logic [5:0] F_SYSCALL = 6'h0C;
    localparam logic [5:0] F_BREAK   = 6'h0D;
    localparam logic [5:0] F_MFHI    = 6'h10;
    localparam logic [5:0] F_MTHI    = 6'h11;
    localparam logic [5:0] F_MFLO    = 6'h12;
    localparam logic [5:0] F_MTLO    = 6'h13;
    localparam logic [5:0] F_MULT    = 6'h18;
    localparam logic [5:0] F_MULTU   = 6'h19;
    localparam logic [5:0] F_DIV     = 6'h1A;
    localparam logic [5:0] F_DIVU    = 6'h1B;
    localparam logic [5:0] F_ADD     = 6'h20;
    localparam logic [5:0] F_ADDU    = 6'h21;
    localparam logic [5:0] F_SUB     = 6'h22;
    localparam logic [5:0] F_SUBU    = 6'h23;
    localparam logic [5:0] F_AND     = 6'h24;
    localparam logic [5:0] F_OR      = 6'h25;
    localparam logic [5:0] F_XOR     = 6'h26;
    localparam logic [5:0] F_NOR     = 6'h27;
    localparam logic [5:0] F_SLT     = 6'h2A;
    localparam logic [5:0] F_SLTU    = 6'h2B;
    localparam logic [5:0] F_RFE     = 6'h10;

    // regimm rt selector
    localparam logic [4:0] RT_BLTZ   = 5'h00;
    localparam logic [4:0] RT_BGEZ   = 5'h01;
    localparam logic [4:0] RT_BLTZAL = 5'h10;
    localparam logic [4:0] RT_BGEZAL = 5'h11;

    // coprocessor rs selector
    localparam logic [4:0] RS_MF = 5'h00;
    localparam logic [4:0] RS_CF = 5'h02;
    localparam logic [4:0] RS_MT = 5'h04;
    localparam logic [4:0] RS_CT = 5'h06;
    localparam logic [4:0] RS_BC = 5'h08;
    localparam logic [4:0] RS_CO = 5'h10;

    // coprocessor branch condition in rt
    localparam logic [4:0] BC_FALSE = 5'h00;
    localparam logic [4:0] BC_TRUE  = 5'h01;

    // geometry command function values, index equals mnemonic code
    localparam int GEO_COUNT = 22;
    localparam logic [5:0] GEO_FUNCT [GEO_COUNT] = '{
        6'h01, 6'h06, 6'h0C, 6'h10, 6'h11, 6'h12, 6'h13, 6'h14, 6'h16, 6'h1B, 6'h1C,
        6'h1E, 6'h20, 6'h28, 6'h29, 6'h2A, 6'h2D, 6'h2E, 6'h30, 6'h3D, 6'h3E, 6'h3F
    };

    localparam logic [31:0] PC_STEP = 32'd4;

    // field stage to decode stage
    typedef struct packed {
        logic [31:0] word;
        logic [31:0] pc_plus4;
        logic [31:0] jtarget;
    } t_s1;

    // decode stage to resolve stage
    typedef struct packed {
        logic [31:0] word;
        t_mnem       code;
        logic        found;
        logic        brk;
        logic        hast;
        logic [31:0] target;
    } t_s2;

    // final result word
    typedef struct packed {
        t_mnem       code;
        logic        illegal;
        logic        brk;
        logic        hast;
        logic [31:0] target;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sa;
        logic [15:0] imm;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/rpd_field_stage.sv =====
// ----------------------------------------------------------------------------
// rpd_field_stage
// first stage: captures the word, forms pc+4 and the jump target
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_field_stage
    import rpd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_up_valid,
    output logic             o_up_ready,
    input  wire logic [31:0] i_word,
    input  wire logic [31:0] i_pc,
    output logic             o_valid,
    output t_s1              o_data,
    input  wire logic        i_dn_ready
);

    logic r_valid;
    t_s1  r_data;
    t_s1  n_data;

    assign o_up_ready = !r_valid || i_dn_ready;

    always_comb begin
        n_data.word     = i_word;
        n_data.pc_plus4 = i_pc + PC_STEP;
        n_data.jtarget  = {i_pc[31:28], i_word[25:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_up_ready && i_up_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/rpd_decode_stage.sv =====
// ----------------------------------------------------------------------------
// rpd_decode_stage
// second stage: mnemonic decode, alias rules and branch target add
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_decode_stage
    import rpd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_up_valid,
    output logic      o_up_ready,
    input  wire t_s1  i_data,
    output logic      o_valid,
    output t_s2       o_data,
    input  wire logic i_dn_ready
);

    logic        r_valid;
    t_s2         r_data;
    t_s2         n_data;

    logic [5:0]  op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [5:0]  fn;
    logic [31:0] btarget;
    logic        use_jump;
    t_mnem       code;
    logic        found;
    logic        brk;
    logic        hast;

    assign o_up_ready = !r_valid || i_dn_ready;

    assign op = i_data.word[31:26];
    assign rs = i_data.word[25:21];
    assign rt = i_data.word[20:16];
    assign rd = i_data.word[15:11];
    assign sa = i_data.word[10:6];
    assign fn = i_data.word[5:0];

    assign btarget = i_data.pc_plus4
                   + {{14{i_data.word[15]}}, i_data.word[15:0], 2'b00};

    always_comb begin
        code     = M_UNKNOWN;
        found    = 1'b1;
        brk      = 1'b0;
        hast     = 1'b0;
        use_jump = 1'b0;
        unique case (op)
            OP_SPECIAL: begin
                unique case (fn)
                    F_SLL:     code = (rd == 5'd0 && rt == 5'd0 && sa == 5'd0) ? M_NOP : M_SLL;
                    F_SRL:     code = M_SRL;
                    F_SRA:     code = M_SRA;
                    F_SLLV:    code = M_SLLV;
                    F_SRLV:    code = M_SRLV;
                    F_SRAV:    code = M_SRAV;
                    F_JR: begin
                        code = M_JR;
                        brk  = 1'b1;
                    end
                    F_JALR:    code = M_JALR;
                    F_SYSCALL: begin
                        code = M_SYSCALL;
                        brk  = 1'b1;
                    end
                    F_BREAK: begin
                        code = M_BREAK;
                        brk  = 1'b1;
                    end
                    F_MFHI:    code = M_MFHI;
                    F_MTHI:    code = M_MTHI;
                    F_MFLO:    code = M_MFLO;
                    F_MTLO:    code = M_MTLO;
                    F_MULT:    code = M_MULT;
                    F_MULTU:   code = M_MULTU;
                    F_DIV:     code = M_DIV;
                    F_DIVU:    code = M_DIVU;
                    F_ADD:     code = M_ADD;
                    F_ADDU:    code = (rs == 5'd0) ? M_MOVE : M_ADDU;
                    F_SUB:     code = M_SUB;
                    F_SUBU:    code = M_SUBU;
                    F_AND:     code = M_AND;
                    F_OR:      code = (rs == 5'd0) ? M_MOVE : M_OR;
                    F_XOR:     code = M_XOR;
                    F_NOR:     code = M_NOR;
                    F_SLT:     code = M_SLT;
                    F_SLTU:    code = M_SLTU;
                    default:   found = 1'b0;
                endcase
            end
            OP_REGIMM: begin
                hast = 1'b1;
                unique case (rt)
                    RT_BLTZ:   code = M_BLTZ;
                    RT_BGEZ:   code = M_BGEZ;
                    RT_BLTZAL: code = M_BLTZAL;
                    RT_BGEZAL: code = M_BGEZAL;
                    default:   found = 1'b0;
                endcase
            end
            OP_J: begin
                code     = M_J;
                brk      = 1'b1;
                hast     = 1'b1;
                use_jump = 1'b1;
            end
            OP_JAL: begin
                code     = M_JAL;
                hast     = 1'b1;
                use_jump = 1'b1;
            end
            OP_BEQ: begin
                hast = 1'b1;
                if (rt != 5'd0) begin
                    code = M_BEQ;
                end else if (rs == 5'd0) begin
                    code = M_B;
                end else begin
                    code = M_BEQZ;
                end
            end
            OP_BNE: begin
                hast = 1'b1;
                code = (rt == 5'd0) ? M_BNEZ : M_BNE;
            end
            OP_BLEZ: begin
                hast = 1'b1;
                code = M_BLEZ;
            end
            OP_BGTZ: begin
                hast = 1'b1;
                code = M_BGTZ;
            end
            OP_ADDI:  code = M_ADDI;
            OP_ADDIU: code = (rs == 5'd0) ? M_LI : M_ADDIU;
            OP_SLTI:  code = M_SLTI;
            OP_SLTIU: code = M_SLTIU;
            OP_ANDI:  code = M_ANDI;
            OP_ORI:   code = (rs == 5'd0) ? M_LI : M_ORI;
            OP_XORI:  code = M_XORI;
            OP_LUI:   code = M_LUI;
            OP_COP0: begin
                unique case (rs)
                    RS_MF: code = M_MFC0;
                    RS_CF: code = M_CFC0;
                    RS_MT: code = M_MTC0;
                    RS_CT: code = M_CTC0;
                    RS_BC: begin
                        hast = 1'b1;
                        unique case (rt)
                            BC_FALSE: code = M_BC0F;
                            BC_TRUE:  code = M_BC0T;
                            default:  found = 1'b0;
                        endcase
                    end
                    RS_CO: begin
                        if (fn == F_RFE) begin
                            code = M_RFE;
                        end else begin
                            found = 1'b0;
                        end
                    end
                    default: found = 1'b0;
                endcase
            end
            OP_COP2: begin
                if (i_data.word[25]) begin
                    // geometry command, unnamed functions are flagged in the last stage
                    code = M_GEO_UNNAMED;
                    for (int i = 0; i < GEO_COUNT; i++) begin
                        if (GEO_FUNCT[i] == fn) begin
                            code = t_mnem'(7'(i));
                        end
                    end
                end else begin
                    unique case (rs)
                        RS_MF: code = M_MFC2;
                        RS_CF: code = M_CFC2;
                        RS_MT: code = M_MTC2;
                        RS_CT: code = M_CTC2;
                        RS_BC: begin
                            hast = 1'b1;
                            unique case (rt)
                                BC_FALSE: code = M_BC2F;
                                BC_TRUE:  code = M_BC2T;
                                default:  found = 1'b0;
                            endcase
                        end
                        default: found = 1'b0;
                    endcase
                end
            end
            OP_LB:   code = M_LB;
            OP_LH:   code = M_LH;
            OP_LWL:  code = M_LWL;
            OP_LW:   code = M_LW;
            OP_LBU:  code = M_LBU;
            OP_LHU:  code = M_LHU;
            OP_LWR:  code = M_LWR;
            OP_SB:   code = M_SB;
            OP_SH:   code = M_SH;
            OP_SWL:  code = M_SWL;
            OP_SW:   code = M_SW;
            OP_SWR:  code = M_SWR;
            OP_LWC2: code = M_LWC2;
            OP_SWC2: code = M_SWC2;
            default: found = 1'b0;
        endcase
    end

    always_comb begin
        n_data.word   = i_data.word;
        n_data.code   = code;
        n_data.found  = found;
        n_data.brk    = brk;
        n_data.hast   = hast;
        n_data.target = use_jump ? i_data.jtarget : btarget;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_up_ready && i_up_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/rpd_resolve_stage.sv =====
// ----------------------------------------------------------------------------
// rpd_resolve_stage
// last stage: unknown-word override, illegal flag, target gating, output register
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_resolve_stage
    import rpd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_up_valid,
    output logic      o_up_ready,
    input  wire t_s2  i_data,
    output logic      o_valid,
    output t_result   o_data,
    input  wire logic i_dn_ready
);

    logic    r_valid;
    t_result r_data;
    t_result n_data;

    assign o_up_ready = !r_valid || i_dn_ready;

    always_comb begin
        n_data.code    = i_data.found ? i_data.code : M_UNKNOWN;
        n_data.illegal = !i_data.found || (i_data.code == M_GEO_UNNAMED);
        n_data.brk     = i_data.found && i_data.brk;
        n_data.hast    = i_data.found && i_data.hast;
        n_data.target  = (i_data.found && i_data.hast) ? i_data.target : 32'd0;
        n_data.rs      = i_data.word[25:21];
        n_data.rt      = i_data.word[20:16];
        n_data.rd      = i_data.word[15:11];
        n_data.sa      = i_data.word[10:6];
        n_data.imm     = i_data.word[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_up_ready && i_up_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/risc_instruction_predecoder.sv =====
// ----------------------------------------------------------------------------
// risc_instruction_predecoder
// three-stage predecoder: mnemonic code, flow flags, static target, raw fields
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  --------  ---------  -----------------  ----------------------------------
//  in        input      i_valid / o_stall  i_instr_word, i_instr_address
//  out       output     o_valid / i_stall  o_mnemonic_code .. o_immediate
//
//  one word per cycle sustained while i_stall is low; an accepted word passes
//  the field, decode and resolve register stages in turn before o_valid
//  synchronous active-low reset empties all stages; no state beyond them
//  each stage holds while the one after it is full and stalled, so a
//  stalled output holds and bubbles close up behind it
//
`default_nettype none

module risc_instruction_predecoder
    import rpd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input word
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_instr_word,
    input  wire logic [31:0] i_instr_address,
    // result word
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [6:0]       o_mnemonic_code,
    output logic             o_is_illegal,
    output logic             o_breaks_flow,
    output logic             o_target_known,
    output logic [31:0]      o_target_address,
    output logic [4:0]       o_reg_s,
    output logic [4:0]       o_reg_t,
    output logic [4:0]       o_reg_d,
    output logic [4:0]       o_shift_amount,
    output logic [15:0]      o_immediate
);

`include "risc_instruction_predecoder_macros.svh"

    // stage handshakes
    logic    s1_ready;
    logic    s1_valid;
    t_s1     s1_data;
    logic    s2_ready;
    logic    s2_valid;
    t_s2     s2_data;
    logic    s3_ready;
    logic    s3_valid;
    t_result s3_data;

    // capture word, pc+4, jump target
    rpd_field_stage u_field (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (i_valid),
        .o_up_ready (s1_ready),
        .i_word     (i_instr_word),
        .i_pc       (i_instr_address),
        .o_valid    (s1_valid),
        .o_data     (s1_data),
        .i_dn_ready (s2_ready)
    );

    // opcode decode and branch add
    rpd_decode_stage u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (s1_valid),
        .o_up_ready (s2_ready),
        .i_data     (s1_data),
        .o_valid    (s2_valid),
        .o_data     (s2_data),
        .i_dn_ready (s3_ready)
    );

    // unknown override and output register
    rpd_resolve_stage u_resolve (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (s2_valid),
        .o_up_ready (s3_ready),
        .i_data     (s2_data),
        .o_valid    (s3_valid),
        .o_data     (s3_data),
        .i_dn_ready (!i_stall)
    );

    // front stalls only when every stage is full and the output is stalled
    assign o_stall = !s1_ready;

    assign o_valid          = s3_valid;
    assign o_mnemonic_code  = s3_data.code;
    assign o_is_illegal     = s3_data.illegal;
    assign o_breaks_flow    = s3_data.brk;
    assign o_target_known   = s3_data.hast;
    assign o_target_address = s3_data.target;
    assign o_reg_s          = s3_data.rs;
    assign o_reg_t          = s3_data.rt;
    assign o_reg_d          = s3_data.rd;
    assign o_shift_amount   = s3_data.sa;
    assign o_immediate      = s3_data.imm;

    // an accepted word always lands in the first stage
    `RPD_ASSERT_NEXT(a_accept_fills_s1, i_valid && !o_stall, s1_valid)

    // illegal words carry no flow break and no target
    `RPD_ASSERT_NOW(a_illegal_clean, o_valid && o_is_illegal,
        !o_breaks_flow && !o_target_known && o_target_address == 32'd0)

    // no target means a zero address
    `RPD_ASSERT_NOW(a_no_target_zero, o_valid && !o_target_known,
        o_target_address == 32'd0)

    // only jump, jump-register, syscall and break end the straight-line flow
    `RPD_ASSERT_NOW(a_break_codes, o_valid && o_breaks_flow,
        o_mnemonic_code == M_J || o_mnemonic_code == M_JR ||
        o_mnemonic_code == M_SYSCALL || o_mnemonic_code == M_BREAK)

    // jump targets are word aligned
    `RPD_ASSERT_NOW(a_jump_aligned,
        o_valid && (o_mnemonic_code == M_J || o_mnemonic_code == M_JAL),
        o_target_known && o_target_address[1:0] == 2'b00)

endmodule

`default_nettype wire
